// ===== hw/rtl/palette_index_builder_core_macros.svh =====
// ----------------------------------------------------------------------------
// palette_index_builder_core_macros.svh
// Assertion macros used by the palette index builder search controller.
// ----------------------------------------------------------------------------
`ifndef PALETTE_INDEX_BUILDER_CORE_MACROS_SVH
`define PALETTE_INDEX_BUILDER_CORE_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define PIB_ASSERT_HOLDS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PIB_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PIB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pib_pkg.sv =====
// ----------------------------------------------------------------------------
// pib_pkg
// Types, command codes and helpers shared by the palette index builder.
// ----------------------------------------------------------------------------
package pib_pkg;

    localparam int PIB_COLOR_W = 24;
    localparam int PIB_ADDR_W  = 8;
    localparam int PIB_COUNT_W = 9;

    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // Palette memory access from the controller
    typedef struct packed {
        logic                   rd_en;
        logic [PIB_ADDR_W-1:0]  rd_addr;
        logic                   wr_en;
        logic [PIB_ADDR_W-1:0]  wr_addr;
        logic [PIB_COLOR_W-1:0] wr_data;
        logic                   clr;
    } mem_req_t;

    // One result item
    typedef struct packed {
        logic [PIB_ADDR_W-1:0]  color_index;
        logic                   palette_full;
        logic [PIB_COUNT_W-1:0] color_count;
        logic [PIB_COLOR_W-1:0] entry_color;
    } result_t;

    // Grayscale ramp: entry i holds i*0x010101
    function automatic logic [PIB_COLOR_W-1:0] ramp_color(input logic [PIB_ADDR_W-1:0] idx);
        ramp_color = {idx, idx, idx};
    endfunction

endpackage

// ===== hw/rtl/palette_index_builder_core.sv =====
// ----------------------------------------------------------------------------
// palette_index_builder_core
// Exact-color palette builder for 24-bit RGB pixels, with read-back and clear.
// ----------------------------------------------------------------------------
// One item is processed at a time. A map command walks the stored palette with
// one memory read per cycle, limited by the single palette memory read port.
// Clear is immediate: no sweep through the memory. The output register lets
// the next item be accepted while a result waits to be taken. pixel_mask is
// written through the cfg channel and applies to pixels mapped after the write.
// ----------------------------------------------------------------------------
module palette_index_builder_core #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_command,
    input  logic [pib_pkg::PIB_COLOR_W-1:0]     s_pixel,
    input  logic [pib_pkg::PIB_ADDR_W-1:0]      s_entry_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pib_pkg::PIB_ADDR_W-1:0]      m_color_index,
    output logic                                m_palette_full,
    output logic [pib_pkg::PIB_COUNT_W-1:0]     m_color_count,
    output logic [pib_pkg::PIB_COLOR_W-1:0]     m_entry_color,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pib_pkg::PIB_COLOR_W-1:0]     cfg_pixel_mask
);
    import pib_pkg::*;

    logic [PIB_COLOR_W-1:0] pixel_mask_reg;
    mem_req_t               mem_req;
    logic [PIB_COLOR_W-1:0] mem_rd_data;
    logic                   res_valid;
    logic                   res_ready;
    result_t                res;
    logic                   out_valid_reg;
    result_t                out_res_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_mask_reg <= '1;
        end else if (cfg_valid && cfg_ready) begin
            pixel_mask_reg <= cfg_pixel_mask;
        end
    end

    pib_search_ctrl #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .command     (s_command),
        .pixel       (s_pixel),
        .entry_index (s_entry_index),
        .pixel_mask  (pixel_mask_reg),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    pib_palette_mem #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mem_req (mem_req),
        .rd_data (mem_rd_data)
    );

    // Output register: load when empty or being drained
    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_res_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_color_index  = out_res_reg.color_index;
    assign m_palette_full = out_res_reg.palette_full;
    assign m_color_count  = out_res_reg.color_count;
    assign m_entry_color  = out_res_reg.entry_color;

endmodule

// ===== hw/rtl/pib_palette_mem.sv =====
// ----------------------------------------------------------------------------
// pib_palette_mem
// Palette store: one write port, one read port with registered data. An entry
// not written since the last clear reads as its grayscale ramp value.
// ----------------------------------------------------------------------------
module pib_palette_mem #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pib_pkg::mem_req_t                   mem_req,
    output logic [pib_pkg::PIB_COLOR_W-1:0]     rd_data
);
    import pib_pkg::*;

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [PIB_COLOR_W-1:0]   mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] valid_reg;
    logic [PIB_COLOR_W-1:0]   rd_raw_reg;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         rd_addr_reg;
    logic [IDX_W-1:0]         wr_idx;
    logic [IDX_W-1:0]         rd_idx;

    assign wr_idx = mem_req.wr_addr[IDX_W-1:0];
    assign rd_idx = mem_req.rd_addr[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[wr_idx] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            rd_raw_reg  <= mem[rd_idx];
            rd_vld_reg  <= valid_reg[rd_idx];
            rd_addr_reg <= rd_idx;
        end
    end

    // Clear drops every valid bit at once; entries then fall back to the ramp
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_req.clr) begin
            valid_reg <= '0;
        end else if (mem_req.wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : ramp_color(PIB_ADDR_W'(rd_addr_reg));

endmodule

// ===== hw/rtl/pib_search_ctrl.sv =====
// ----------------------------------------------------------------------------
// pib_search_ctrl
// Command sequencer: linear palette search with one read per cycle, append
// on miss while room remains, clear and read-back. Holds the used-entry count.
// ----------------------------------------------------------------------------
`include "palette_index_builder_core_macros.svh"

module pib_search_ctrl #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          command,
    input  logic [pib_pkg::PIB_COLOR_W-1:0]     pixel,
    input  logic [pib_pkg::PIB_ADDR_W-1:0]      entry_index,
    input  logic [pib_pkg::PIB_COLOR_W-1:0]     pixel_mask,
    output pib_pkg::mem_req_t                   mem_req,
    input  logic [pib_pkg::PIB_COLOR_W-1:0]     mem_rd_data,
    output logic                                res_valid,
    input  logic                                res_ready,
    output pib_pkg::result_t                    res
);
    import pib_pkg::*;

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_INSERT,
        ST_READ,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [PIB_COLOR_W-1:0] pix_reg;
    logic [CNT_W-1:0]       issue_reg;
    logic                   cmp_valid_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic                   cmp_last_reg;
    logic [PIB_ADDR_W-1:0]  idx_out_reg;
    logic [PIB_COLOR_W-1:0] entry_out_reg;

    cmd_t                   cmd;
    logic                   accept;
    logic                   issue_ok;
    logic                   hit;
    logic                   in_range;
    logic                   has_room;
    logic [CNT_W-1:0]       issue_inc;
    logic [CNT_W-1:0]       count_inc;

    assign cmd       = cmd_t'(command);
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign issue_ok  = (issue_reg < count_reg);
    assign hit       = cmp_valid_reg && (mem_rd_data == pix_reg);
    assign in_range  = ({1'b0, entry_index} < PIB_COUNT_W'(PALETTE_DEPTH));
    assign has_room  = (count_reg < DEPTH_CNT);
    assign issue_inc = CNT_W'(issue_reg + CNT_W'(1));
    assign count_inc = CNT_W'(count_reg + CNT_W'(1));

    // Memory requests. Reads and the append never address the same entry in
    // one cycle: search reads stop below the count, the append writes at it.
    always_comb begin
        mem_req         = '0;
        mem_req.wr_addr = PIB_ADDR_W'(count_reg[IDX_W-1:0]);
        mem_req.wr_data = pix_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (cmd == CMD_READ) && in_range) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = entry_index;
                end
                if (accept && (cmd == CMD_CLEAR)) begin
                    mem_req.clr = 1'b1;
                end
            end
            ST_SEARCH: begin
                mem_req.rd_en   = issue_ok;
                mem_req.rd_addr = PIB_ADDR_W'(issue_reg[IDX_W-1:0]);
                mem_req.wr_en   = cmp_valid_reg && !hit && cmp_last_reg && has_room;
            end
            ST_INSERT: begin
                mem_req.wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        idx_out_reg   <= '0;
                        entry_out_reg <= '0;
                        unique case (cmd)
                            CMD_MAP: begin
                                pix_reg       <= pixel & pixel_mask;
                                issue_reg     <= '0;
                                cmp_valid_reg <= 1'b0;
                                state_reg     <= (count_reg == '0) ? ST_INSERT : ST_SEARCH;
                            end
                            CMD_CLEAR: begin
                                count_reg <= '0;
                                state_reg <= ST_DONE;
                            end
                            CMD_READ: begin
                                state_reg <= in_range ? ST_READ : ST_DONE;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SEARCH: begin
                    // Issue one read per cycle, compare the one issued before
                    cmp_valid_reg <= issue_ok;
                    cmp_idx_reg   <= issue_reg[IDX_W-1:0];
                    cmp_last_reg  <= (issue_inc == count_reg);
                    if (issue_ok) begin
                        issue_reg <= issue_inc;
                    end
                    if (hit) begin
                        idx_out_reg   <= PIB_ADDR_W'(cmp_idx_reg);
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= ST_DONE;
                    end else if (cmp_valid_reg && cmp_last_reg) begin
                        // Miss: append if there is room, else report index 0
                        if (has_room) begin
                            idx_out_reg <= PIB_ADDR_W'(count_reg[IDX_W-1:0]);
                            count_reg   <= count_inc;
                        end
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= ST_DONE;
                    end
                end
                ST_INSERT: begin
                    count_reg <= count_inc;
                    state_reg <= ST_DONE;
                end
                ST_READ: begin
                    entry_out_reg <= mem_rd_data;
                    state_reg     <= ST_DONE;
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid        = (state_reg == ST_DONE);
    assign res.color_index  = idx_out_reg;
    assign res.palette_full = (count_reg == DEPTH_CNT);
    assign res.color_count  = PIB_COUNT_W'(count_reg);
    assign res.entry_color  = entry_out_reg;

    `PIB_ASSERT_HOLDS(a_count_range, aclk, aresetn, count_reg <= DEPTH_CNT, "count above depth")
    `PIB_ASSERT_IMPLIES(a_wr_at_tail, aclk, aresetn, mem_req.wr_en, (mem_req.wr_addr == PIB_ADDR_W'(count_reg[IDX_W-1:0])) && has_room, "append not at tail")
    `PIB_ASSERT_IMPLIES(a_no_rd_on_wr, aclk, aresetn, mem_req.wr_en, !mem_req.rd_en, "read during append")
    `PIB_ASSERT_NEXT(a_clear_empties, aclk, aresetn, accept && (cmd == CMD_CLEAR), count_reg == '0, "clear left entries")
    `PIB_ASSERT_IMPLIES(a_hit_in_range, aclk, aresetn, (state_reg == ST_SEARCH) && hit, CNT_W'(cmp_idx_reg) < count_reg, "hit beyond count")

endmodule
